// ===== design/rprf_pkg.sv =====
// ----------------------------------------------------------------------------
// rprf_pkg
// Shared constants for the RTP receive filter: header layout, status codes
// and the default packet size limit.
// ----------------------------------------------------------------------------
package rprf_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 4096;

    localparam int HDR_W        = 7;
    localparam int FIXED_HEADER = 12;
    localparam int RTP_VERSION  = 2;

    localparam logic [3:0] CSRC_MASK = 4'hF;
    localparam logic [6:0] KIND_MASK = 7'h7F;

    typedef logic [3:0] t_status;

    localparam t_status ST_IN_ORDER     = 4'd0;
    localparam t_status ST_GAP_RESYNC   = 4'd1;
    localparam t_status ST_CONNECTED    = 4'd2;
    localparam t_status ST_STALE        = 4'd3;
    localparam t_status ST_SHORT        = 4'd4;
    localparam t_status ST_VERSION      = 4'd5;
    localparam t_status ST_PADDING      = 4'd6;
    localparam t_status ST_EXTENSION    = 4'd7;
    localparam t_status ST_CSRC_SHORT   = 4'd8;
    localparam t_status ST_DISCONNECTED = 4'd9;

    localparam logic [15:0] SEQ_HALF = 16'h8000;

endpackage

// ===== design/rtp_packet_receive_filter.sv =====
// ----------------------------------------------------------------------------
// Path: input register, processing stage, result register. Throughput: one
//   item per cycle unless the output stalls; the byte position counter, header
//   compare and sequence compare all settle in the single processing stage.
// Reset (synchronous, active low) disconnects the link, zeroes the expected
//   sequence number and starts a fresh packet.
// ----------------------------------------------------------------------------
// rtp_packet_receive_filter
// RTP datagram header check, connect and sequence tracking, and payload
// forwarding, one byte or timeout event per item.
// ----------------------------------------------------------------------------
module rtp_packet_receive_filter
    import rprf_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic        o_status_valid,
    output logic [3:0]  o_status_code,
    output logic [6:0]  o_payload_kind,
    output logic [15:0] o_packet_sequence,
    output logic [15:0] o_expected_next
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = ((POS_W > HDR_W) ? POS_W : HDR_W) + 1;
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_PACKET_BYTES);
    localparam logic [CMP_W-1:0] FIXED_CMP = CMP_W'(FIXED_HEADER);

    // input register
    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_byte;
    logic        r_last;

    // packet and link state
    logic             r_link_up,  n_link_up;
    logic [15:0]      r_next_seq, n_next_seq;
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [3:0]       r_csrc,     n_csrc;
    t_status          r_reason,   n_reason;
    logic [7:0]       r_seq_hi,   n_seq_hi;
    logic [7:0]       r_seq_lo,   n_seq_lo;
    logic [6:0]       r_kind,     n_kind;
    logic             r_fwd,      n_fwd;

    // result register
    logic        r_out_valid;
    logic        r_pv, n_pv;
    logic [7:0]  r_pb, n_pb;
    logic        r_pl, n_pl;
    logic        r_sv, n_sv;
    t_status     r_sc, n_sc;
    logic [6:0]  r_sk, n_sk;
    logic [15:0] r_ss, n_ss;
    logic [15:0] r_se, n_se;

    logic             w_res;
    logic             w_advance;
    logic             w_room;
    logic [CMP_W-1:0] w_p;
    logic [CMP_W-1:0] w_p1;
    logic [CMP_W-1:0] w_n;
    logic [CMP_W-1:0] w_hdr;
    logic [15:0]      w_seq;
    logic [15:0]      w_diff;
    logic             w_stale;

    always_comb begin
        n_link_up  = r_link_up;
        n_next_seq = r_next_seq;
        n_pos      = r_pos;
        n_csrc     = r_csrc;
        n_reason   = r_reason;
        n_seq_hi   = r_seq_hi;
        n_seq_lo   = r_seq_lo;
        n_kind     = r_kind;
        n_fwd      = r_fwd;
        n_pv = 1'b0;
        n_pb = '0;
        n_pl = 1'b0;
        n_sv = 1'b0;
        n_sc = ST_IN_ORDER;
        n_sk = '0;
        n_ss = '0;
        n_se = '0;
        w_res   = 1'b0;
        w_p     = CMP_W'(r_pos);
        w_p1    = w_p + CMP_W'(1);
        w_room  = (w_p < MAX_CMP);
        w_hdr   = '0;
        w_n     = '0;
        w_seq   = '0;
        w_diff  = '0;
        w_stale = 1'b0;

        if (r_op) begin
            // timeout: abandon the packet, disconnect if up
            n_pos    = '0;
            n_csrc   = '0;
            n_reason = ST_IN_ORDER;
            n_seq_hi = '0;
            n_seq_lo = '0;
            n_kind   = '0;
            n_fwd    = 1'b0;
            if (r_link_up) begin
                n_link_up = 1'b0;
                w_res     = 1'b1;
                n_sv      = 1'b1;
                n_sc      = ST_DISCONNECTED;
                n_se      = r_next_seq;
            end
        end else begin
            if (w_room) begin
                if (r_pos == POS_W'(0)) begin
                    n_csrc = r_byte[3:0] & CSRC_MASK;
                    if (r_byte[7:6] != 2'(RTP_VERSION)) begin
                        n_reason = ST_VERSION;
                    end else if (r_byte[5]) begin
                        n_reason = ST_PADDING;
                    end else if (r_byte[4]) begin
                        n_reason = ST_EXTENSION;
                    end
                end else if (r_pos == POS_W'(1)) begin
                    n_kind = r_byte[6:0] & KIND_MASK;
                end else if (r_pos == POS_W'(2)) begin
                    n_seq_hi = r_byte;
                end else if (r_pos == POS_W'(3)) begin
                    n_seq_lo = r_byte;
                end
                w_hdr  = FIXED_CMP + CMP_W'({n_csrc, 2'b00});
                w_seq  = {n_seq_hi, n_seq_lo};
                w_diff = w_seq - r_next_seq;
                w_stale = w_diff[15] && !(w_diff == SEQ_HALF && w_seq > r_next_seq);
                if (n_reason < ST_VERSION) begin
                    if (w_p1 == w_hdr) begin
                        // connect and sequence check
                        if (!r_link_up) begin
                            n_link_up  = 1'b1;
                            n_next_seq = w_seq + 16'd1;
                            n_reason   = ST_CONNECTED;
                            n_fwd      = 1'b1;
                        end else if (w_seq == r_next_seq) begin
                            n_next_seq = r_next_seq + 16'd1;
                            n_reason   = ST_IN_ORDER;
                            n_fwd      = 1'b1;
                        end else if (w_stale) begin
                            n_reason = ST_STALE;
                            n_fwd    = 1'b0;
                        end else begin
                            n_next_seq = w_seq + 16'd1;
                            n_reason   = ST_GAP_RESYNC;
                            n_fwd      = 1'b1;
                        end
                    end else if (w_p >= w_hdr && r_fwd) begin
                        n_pv = 1'b1;
                        n_pb = r_byte;
                        n_pl = r_last || (w_p1 == MAX_CMP);
                    end
                end
                n_pos = POS_W'(w_p1);
            end

            w_res = r_last || n_pv;
            if (r_last) begin
                w_n   = CMP_W'(n_pos);
                w_hdr = FIXED_CMP + CMP_W'({n_csrc, 2'b00});
                n_sv  = 1'b1;
                if (w_n < FIXED_CMP) begin
                    n_sc = ST_SHORT;
                end else if (n_reason >= ST_VERSION) begin
                    n_sc = n_reason;
                end else if (w_n < w_hdr) begin
                    n_sc = ST_CSRC_SHORT;
                end else begin
                    n_sc = n_reason;
                end
                n_sk = n_kind;
                n_ss = {n_seq_hi, n_seq_lo};
                n_se = n_next_seq;
                n_pos    = '0;
                n_csrc   = '0;
                n_reason = ST_IN_ORDER;
                n_seq_hi = '0;
                n_seq_lo = '0;
                n_kind   = '0;
                n_fwd    = 1'b0;
            end
        end
    end

    assign w_advance  = r_in_valid && (!w_res || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op   <= i_operation;
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up  <= 1'b0;
            r_next_seq <= '0;
            r_pos      <= '0;
            r_csrc     <= '0;
            r_reason   <= ST_IN_ORDER;
            r_seq_hi   <= '0;
            r_seq_lo   <= '0;
            r_kind     <= '0;
            r_fwd      <= 1'b0;
        end else if (w_advance) begin
            r_link_up  <= n_link_up;
            r_next_seq <= n_next_seq;
            r_pos      <= n_pos;
            r_csrc     <= n_csrc;
            r_reason   <= n_reason;
            r_seq_hi   <= n_seq_hi;
            r_seq_lo   <= n_seq_lo;
            r_kind     <= n_kind;
            r_fwd      <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res) begin
            r_pv <= n_pv;
            r_pb <= n_pb;
            r_pl <= n_pl;
            r_sv <= n_sv;
            r_sc <= n_sc;
            r_sk <= n_sk;
            r_ss <= n_ss;
            r_se <= n_se;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_valid   = r_pv;
    assign o_payload_byte    = r_pb;
    assign o_payload_last    = r_pl;
    assign o_status_valid    = r_sv;
    assign o_status_code     = r_sc;
    assign o_payload_kind    = r_sk;
    assign o_packet_sequence = r_ss;
    assign o_expected_next   = r_se;

    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_last |-> o_payload_valid)
        else $error("payload_last without payload byte");

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_valid || o_status_valid))
        else $error("empty result delivered");

    a_timeout_drops_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_op |=> !r_link_up && r_pos == '0)
        else $error("timeout left link or packet state");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_pos) <= MAX_CMP)
        else $error("byte position beyond limit");

    a_disconnect_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_code == ST_DISCONNECTED
            |-> o_packet_sequence == '0 && o_payload_kind == '0 && !o_payload_valid)
        else $error("disconnect status carries packet fields");

endmodule
